/* rtl/core/dnhc_pkg.sv */
// Package with the shared types and constants of the directory name hash cache.
package dnhc_pkg;
    typedef enum logic [1:0] {
        FUNC_LOOKUP     = 2'd0,
        FUNC_INSERT     = 2'd1,
        FUNC_INVALIDATE = 2'd2,
        FUNC_NONE       = 2'd3
    } func_t;

    localparam logic [31:0] HASH_SEED_MUL = 32'd2654435761;

    // The entry index is taken from the low hash bits, so the count is a power of two.
    localparam int CACHE_ENTRIES = 512;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SEED  = 7'b0000010,
        ST_RECV  = 7'b0000100,
        ST_READ  = 7'b0001000,
        ST_CMP   = 7'b0010000,
        ST_WRITE = 7'b0100000,
        ST_CLEAR = 7'b1000000
    } state_t;
endpackage

/* rtl/core/directory_name_hash_cache.sv */
// Top level of the directory name hash cache.
// A request arrives as a stream of name bytes on the input channel (valid, stall),
// one byte per accepted item. func, parent_inode and child_inode are taken from
// the first byte; name_last marks the final byte and ends the request.
// Each request that ends gives one result on the output channel: hit, rejected
// and inode_out. The seed hash (parent times the golden ratio constant) is built
// bit-serially after the first byte, during which the input stalls. Each byte is
// first buffered and then folded into the hash (hash times 31 plus the byte, by
// shift, subtract and add). After the last byte the entry is read, the stored
// name is compared one byte per cycle, and on insert the name is written one
// byte per cycle. A miss or a rejected request leaves the compare early.
// The result sits in an output register; when the receiver stalls it holds, and
// the next request runs up to the entry read and waits there until it is taken.
// Reset clears the control state and starts a clearing pass over all CACHE_ENTRIES
// entries that writes every valid mark to zero; the input stalls until it ends.
module directory_name_hash_cache #(
    parameter int NAME_BYTES    = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [31:0] parent_inode,
    input  logic [31:0] child_inode,
    input  logic [7:0]  name_byte,
    input  logic        name_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit,
    output logic        rejected,
    output logic [31:0] inode_out
);
    import dnhc_pkg::*;

    localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int BW = $clog2(NAME_BYTES);
    localparam int CW = $clog2(NAME_BYTES + 1);
    localparam int AW = IW + BW;

    state_t          state_reg, state_next;
    func_t           func_reg;
    logic [31:0]     parent_reg, child_reg;
    logic [31:0]     hash_reg;
    logic [31:0]     mul_a_reg;   // multiplicand shifting left
    logic [31:0]     mul_b_reg;   // multiplier shifting right
    logic [5:0]      bit_cnt_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   pos_reg;
    logic            last_reg;
    logic [7:0]      byte_reg;
    logic            pend_reg;    // a buffered byte waits to be hashed
    logic            match_reg;
    logic            out_valid_reg, hit_reg, rej_reg;
    logic [31:0]     inode_reg;
    logic [IW-1:0]   clr_cnt_reg;

    logic        valid_mem [CACHE_ENTRIES];
    logic [7:0]  buf_mem [NAME_BYTES];
    logic [7:0]  name_mem [2**AW];
    logic [31:0] parent_mem [CACHE_ENTRIES];
    logic [31:0] child_mem [CACHE_ENTRIES];
    logic [CW-1:0] len_mem [CACHE_ENTRIES];

    logic [31:0]   ent_parent_reg, ent_child_reg;
    logic [CW-1:0] ent_len_reg;
    logic [7:0]    ent_byte_reg, buf_byte_reg;

    logic [IW-1:0] idx;
    logic          in_acc, out_free;
    logic [31:0]   hash_step;
    logic          bad_len;

    assign idx       = hash_reg[IW-1:0];
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == ST_IDLE)
                         || ((state_reg == ST_RECV) && !pend_reg && !last_reg));
    assign in_acc    = in_valid && !in_stall;
    assign hash_step = {hash_reg[26:0], 5'd0} - hash_reg + {24'd0, byte_reg};
    assign bad_len   = (count_reg == CW'(0)) || (count_reg >= CW'(NAME_BYTES));

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign rejected  = rej_reg;
    assign inode_out = inode_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_cnt_reg == IW'(CACHE_ENTRIES - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (in_acc) state_next = ST_SEED;
            ST_SEED:  if (bit_cnt_reg == 6'd31) state_next = ST_RECV;
            ST_RECV:
            begin
                if (pend_reg && last_reg)
                    state_next = ST_READ;
            end
            ST_READ:  if (out_free) state_next = ST_CMP;
            ST_CMP:
            begin
                if (bad_len || func_reg == FUNC_NONE
                    || (func_reg == FUNC_INSERT && child_reg == 32'd0))
                    state_next = ST_IDLE;
                else if (func_reg == FUNC_INSERT)
                    state_next = ST_WRITE;
                else if (!match_reg || pos_reg == count_reg + CW'(1))
                    state_next = ST_IDLE;
            end
            ST_WRITE: if (pos_reg + CW'(1) == count_reg) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            last_reg      <= 1'b0;
            count_reg     <= '0;
            bit_cnt_reg   <= '0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR: clr_cnt_reg <= clr_cnt_reg + IW'(1);
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        bit_cnt_reg <= '0;
                        pend_reg    <= 1'b1;
                        last_reg    <= name_last;
                        count_reg   <= CW'(1);
                    end
                end
                ST_SEED: bit_cnt_reg <= bit_cnt_reg + 6'd1;
                ST_RECV:
                begin
                    if (pend_reg)
                        pend_reg <= 1'b0;
                    else if (in_acc)
                    begin
                        pend_reg <= 1'b1;
                        last_reg <= name_last;
                        if (count_reg < CW'(NAME_BYTES))
                            count_reg <= count_reg + CW'(1);
                    end
                end
                ST_CMP:
                begin
                    if (state_next == ST_IDLE)
                    begin
                        out_valid_reg <= 1'b1;
                        last_reg      <= 1'b0;
                        pend_reg      <= 1'b0;
                    end
                end
                ST_WRITE:
                begin
                    if (state_next == ST_IDLE)
                    begin
                        out_valid_reg <= 1'b1;
                        last_reg      <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath: valid clearing, shift-and-add seed multiply, hash folding, compare and copy.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_CLEAR: valid_mem[clr_cnt_reg] <= 1'b0;
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    func_reg   <= func_t'(func);
                    parent_reg <= parent_inode;
                    child_reg  <= child_inode;
                    byte_reg   <= name_byte;
                    buf_mem[0] <= name_byte;
                    hash_reg   <= '0;
                    mul_a_reg  <= parent_inode;
                    mul_b_reg  <= HASH_SEED_MUL;
                end
            end
            ST_SEED:
            begin
                if (mul_b_reg[0])
                    hash_reg <= hash_reg + mul_a_reg;
                mul_a_reg <= {mul_a_reg[30:0], 1'b0};
                mul_b_reg <= {1'b0, mul_b_reg[31:1]};
            end
            ST_RECV:
            begin
                if (pend_reg)
                    hash_reg <= hash_step;
                else if (in_acc)
                begin
                    byte_reg <= name_byte;
                    if (count_reg < CW'(NAME_BYTES))
                        buf_mem[count_reg[BW-1:0]] <= name_byte;
                end
                pos_reg   <= '0;
                match_reg <= 1'b1;
            end
            ST_READ:
            begin
                // The previous result must be taken before this one is built.
                if (out_free)
                begin
                    ent_parent_reg <= parent_mem[idx];
                    ent_child_reg  <= child_mem[idx];
                    ent_len_reg    <= len_mem[idx];
                    ent_byte_reg   <= name_mem[{idx, BW'(0)}];
                    buf_byte_reg   <= buf_mem[0];
                    pos_reg        <= CW'(1);
                    match_reg      <= valid_mem[idx];
                    hit_reg        <= 1'b0;
                    rej_reg        <= 1'b0;
                    inode_reg      <= '0;
                end
            end
            ST_CMP:
            begin
                if (func_reg == FUNC_INSERT)
                begin
                    if (!bad_len && child_reg != 32'd0)
                    begin
                        parent_mem[idx] <= parent_reg;
                        child_mem[idx]  <= child_reg;
                        len_mem[idx]    <= count_reg;
                    end
                    pos_reg <= '0;
                end
                else
                begin
                    if (pos_reg == CW'(1))
                        match_reg <= match_reg && ent_parent_reg == parent_reg
                                     && ent_len_reg == count_reg
                                     && ent_byte_reg == buf_byte_reg;
                    else
                        match_reg <= match_reg && ent_byte_reg == buf_byte_reg;
                    ent_byte_reg <= name_mem[AW'({idx, pos_reg[BW-1:0]})];
                    buf_byte_reg <= buf_mem[pos_reg[BW-1:0]];
                    pos_reg      <= pos_reg + CW'(1);
                end
                if (bad_len)
                    rej_reg <= 1'b1;
                else if (func_reg == FUNC_INSERT)
                begin
                    if (child_reg == 32'd0)
                        rej_reg <= 1'b1;
                    else
                        hit_reg <= 1'b1;
                end
                else if ((func_reg == FUNC_LOOKUP || func_reg == FUNC_INVALIDATE)
                         && match_reg && pos_reg == count_reg + CW'(1))
                begin
                    hit_reg <= 1'b1;
                    if (func_reg == FUNC_LOOKUP)
                        inode_reg <= ent_child_reg;
                end
                if (!bad_len && func_reg == FUNC_INVALIDATE && match_reg
                    && pos_reg == count_reg + CW'(1))
                    valid_mem[idx] <= 1'b0;
            end
            ST_WRITE:
            begin
                // buf_byte_reg holds the byte for pos_reg; fetch the next one.
                name_mem[{idx, pos_reg[BW-1:0]}] <= buf_byte_reg;
                buf_byte_reg <= buf_mem[pos_reg[BW-1:0] + BW'(1)];
                pos_reg <= pos_reg + CW'(1);
                if (pos_reg + CW'(1) == count_reg)
                    valid_mem[idx] <= 1'b1;
            end
            default: ;
        endcase
    end
endmodule
